// ----- rtl/inversion_table_to_permutation_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef INVERSION_TABLE_TO_PERMUTATION_DEFINES_SVH
`define INVERSION_TABLE_TO_PERMUTATION_DEFINES_SVH
`ifndef SYNTH
`define ITP_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("itp check failed");
`define ITP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp check failed");
`else
`define ITP_ASSERT_NEVER(lbl, expr)
`define ITP_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

// ----- rtl/itp_pkg.sv -----
package itp_pkg;

    localparam int POS_W = 11;
    localparam int CNT_W = 10;
    localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

    typedef struct packed {
        logic             restart;
        logic [CNT_W-1:0] larger_before;
    } req_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] value;
        logic             bad_count;
        logic             last;
    } rsp_t;

endpackage

// ----- rtl/itp_ram.sv -----
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/itp_cell.sv -----
module itp_cell #(
    parameter int LEVELS = 10,
    parameter int LEVEL  = 0,
    parameter int CW     = 11,
    parameter int CLR_W  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr_en,
    input  logic [CLR_W-1:0]  clr_addr,
    input  logic [LEVELS-1:0] raddr_src,
    input  logic              in_valid,
    input  logic [LEVELS-1:0] in_node,
    input  logic [CW-1:0]     in_k,
    output logic              out_valid,
    output logic [LEVELS-1:0] out_node,
    output logic [CW-1:0]     out_k
);

    localparam int DEPTH = (LEVEL < 2) ? 2 : (1 << (LEVEL - 1));
    localparam int AW    = $clog2(DEPTH);
    localparam int HALF  = 1 << (LEVELS - 1 - LEVEL);

    // each row holds the left-child counts of two sibling nodes
    logic [2*CW-1:0]   rd_row;
    logic [2*CW-1:0]   wr_row;
    logic [CW-1:0]     word;
    logic [CW-1:0]     inc;
    logic [CW-1:0]     left_free;
    logic              go_left;
    logic [LEVELS-1:0] node_shr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [2*CW-1:0]   wdata;
    logic              valid_reg;
    logic [LEVELS-1:0] node_reg;
    logic [CW-1:0]     k_reg;

    assign word      = in_node[0] ? rd_row[2*CW-1:CW] : rd_row[CW-1:0];
    assign inc       = word + CW'(1);
    assign left_free = CW'(HALF) - word;
    assign go_left   = (left_free >= in_k);
    assign wr_row    = in_node[0] ? {inc, rd_row[CW-1:0]} : {rd_row[2*CW-1:CW], inc};
    assign node_shr  = in_node >> 1;
    assign we        = clr_en | (in_valid & go_left);
    assign waddr     = clr_en ? clr_addr[AW-1:0] : node_shr[AW-1:0];
    assign wdata     = clr_en ? '0 : wr_row;

    itp_ram #(
        .WIDTH(2 * CW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr_src[AW-1:0]),
        .rdata(rd_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= (in_node << 1) | LEVELS'(!go_left);
        k_reg    <= go_left ? in_k : (in_k - left_free);
    end

    assign out_valid = valid_reg;
    assign out_node  = node_reg;
    assign out_k     = k_reg;

endmodule

// ----- rtl/inversion_table_to_permutation.sv -----
// Rebuilds a permutation of 1..n from inversion counts, one position per item,
// from position n down to 1. A row of $clog2(MAX_SIZE) cells, one per tree
// level, each holding that level's removed-value counts in a small RAM, walks
// the selection down the tree one level a cycle. An item passes from acceptance
// to result through the check state, the launch register, one cell per tree
// level, the taking of the leaf and the loading of the output; a rejected item
// goes from the check straight to the output load. The next item is taken the
// cycle after the result is loaded, and a result still waiting in the output
// register holds the next one back. An item with restart set first clears the
// tree's 2**(log2(MAX_SIZE)-2) RAM rows (256 at 1024), during which no item is
// taken. The size from cfg_data takes effect at the next restart.
`include "inversion_table_to_permutation_defines.svh"
module inversion_table_to_permutation
    import itp_pkg::*;
#(
    parameter int MAX_SIZE = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [POS_W-1:0] cfg_data
);

    localparam int LEVELS   = $clog2(MAX_SIZE);
    localparam int CW       = LEVELS + 1;
    localparam int CLR_ROWS = (LEVELS < 3) ? 2 : (1 << (LEVELS - 2));
    localparam int CLR_W    = $clog2(CLR_ROWS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_DESCEND,
        S_EMIT
    } state_t;

    state_t           state_reg;
    logic [POS_W-1:0] size_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CLR_W-1:0] clr_reg;
    logic             launch_valid_reg;
    logic [CW-1:0]    launch_k_reg;
    rsp_t             res_reg;
    rsp_t             rsp_reg;
    logic             rsp_valid_reg;

    logic [POS_W-1:0] eff_size;
    logic [LEVELS:0]  leaf_val;

    logic [LEVELS:0]   tok_valid;
    logic [LEVELS-1:0] tok_node [LEVELS+1];
    logic [CW-1:0]     tok_k    [LEVELS+1];
    logic [LEVELS-1:0] src_node [LEVELS];

    always_comb
    begin
        eff_size = size_reg;
        if (size_reg == '0)
        begin
            eff_size = POS_W'(1);
        end
        else if (32'(size_reg) > MAX_SIZE)
        begin
            eff_size = POS_W'(MAX_SIZE);
        end
    end

    assign leaf_val = {1'b0, tok_node[LEVELS]} + (LEVELS+1)'(1);

    assign tok_valid[0] = launch_valid_reg;
    assign tok_node[0]  = '0;
    assign tok_k[0]     = launch_k_reg;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_root
            assign src_node[i] = '0;
        end
        else
        begin : g_inner
            assign src_node[i] = tok_node[i-1];
        end

        itp_cell #(
            .LEVELS(LEVELS),
            .LEVEL (i),
            .CW    (CW),
            .CLR_W (CLR_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clr_en   (state_reg == S_CLEAR),
            .clr_addr (clr_reg),
            .raddr_src(src_node[i]),
            .in_valid (tok_valid[i]),
            .in_node  (tok_node[i]),
            .in_k     (tok_k[i]),
            .out_valid(tok_valid[i+1]),
            .out_node (tok_node[i+1]),
            .out_k    (tok_k[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            size_reg         <= SIZE_RESET;
            pos_reg          <= '0;
            count_reg        <= '0;
            clr_reg          <= '0;
            launch_valid_reg <= 1'b0;
            launch_k_reg     <= '0;
            res_reg          <= '0;
            rsp_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
            if (rsp_valid_reg && rsp_ready && state_reg != S_EMIT)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        count_reg <= req.larger_before;
                        clr_reg   <= '0;
                        if (req.restart)
                        begin
                            pos_reg   <= eff_size;
                            state_reg <= S_CLEAR;
                        end
                        else
                        begin
                            state_reg <= S_CHECK;
                        end
                    end
                end
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == CLR_W'(CLR_ROWS - 1))
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    res_reg.position <= pos_reg;
                    res_reg.value    <= '0;
                    if (pos_reg == '0 || POS_W'(count_reg) >= pos_reg)
                    begin
                        res_reg.bad_count <= 1'b1;
                        res_reg.last      <= 1'b0;
                        state_reg         <= S_EMIT;
                    end
                    else
                    begin
                        res_reg.bad_count <= 1'b0;
                        res_reg.last      <= (pos_reg == POS_W'(1));
                        launch_valid_reg  <= 1'b1;
                        launch_k_reg      <= CW'(pos_reg - POS_W'(count_reg));
                        pos_reg           <= pos_reg - POS_W'(1);
                        state_reg         <= S_DESCEND;
                    end
                end
                S_DESCEND:
                begin
                    launch_valid_reg <= 1'b0;
                    if (tok_valid[LEVELS])
                    begin
                        res_reg.value <= POS_W'(leaf_val);
                        state_reg     <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `ITP_ASSERT_NEVER(a_one_token, $countones(tok_valid) > 1)
    `ITP_ASSERT_IMPLY(a_tail_descend, tok_valid[LEVELS], state_reg == S_DESCEND)
    `ITP_ASSERT_IMPLY(a_last_pos, rsp_valid && rsp.last, rsp.position == POS_W'(1) && !rsp.bad_count)
    `ITP_ASSERT_IMPLY(a_bad_zero, rsp_valid && rsp.bad_count, rsp.value == '0)

endmodule
